>>> rtl/grcr_pkg.sv
// ----------------------------------------------------------------------------
// grcr_pkg: shared types and constants of the gauge ratio color ramp
// Holds the stop record, register indexes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none
package grcr_pkg;
  localparam int VAL_W   = 24;
  localparam int RATIO_W = 13;
  localparam int FULL    = 4096;
  localparam int QUO_W   = 12;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W   = 45;

  localparam logic [REG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BLEND      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STOP_FIRST = 3'd2;

  // ratio classes decided ahead of the divider
  localparam logic [1:0] KIND_DIV  = 2'd0;
  localparam logic [1:0] KIND_ZERO = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;

  typedef struct packed {
    logic [RATIO_W-1:0] pos;
    logic [31:0]        color;
  } stop_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [31:0]        color;
  } result_t;
endpackage
`default_nettype wire

>>> rtl/gauge_ratio_color_ramp_core.sv
// ----------------------------------------------------------------------------
// gauge_ratio_color_ramp_core: gauge fill ratio and color ramp tint
//
// channel  direction  fields (low bit first)
// s_axis   in         tdata: current_value[23:0], max_value[47:24]
// m_axis   out        tdata: fill_ratio[12:0], red, green, blue, alpha, pad
// cfg      in         index, data (register write)
//
// One item per cycle unless the output stalls; 12 divider stages, 11 ramp
// stages and the output register. The whole pipe advances when the output
// register is free or being taken, so a stall holds every stage. Reset clears
// valid bits and the registers to their reset values; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module gauge_ratio_color_ramp_core #(
  parameter int STOP_SLOTS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // current_value, max_value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // fill_ratio, red, green, blue, alpha
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [44:0] cfg_data
);
  // config registers
  logic [2:0]        stop_count;
  logic              blend_enable;
  grcr_pkg::stop_t   stops [STOP_SLOTS];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= '0;
      blend_enable <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == grcr_pkg::REG_STOP_COUNT) stop_count <= cfg_data[2:0];
      if (cfg_index == grcr_pkg::REG_BLEND) blend_enable <= cfg_data[0];
    end
  end
  for (genvar i = 0; i < STOP_SLOTS; i++) begin : g_stop
    always_ff @(posedge clk) begin
      if (rst) begin
        stops[i] <= '0;
      end else if (cfg_valid && cfg_index == grcr_pkg::REG_STOP_FIRST + 3'(i)) begin
        stops[i] <= cfg_data;
      end
    end
  end

  // global advance
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // input classification
  logic signed [23:0] cur, mx;
  logic [1:0] kind;
  assign cur = s_axis_tdata[23:0];
  assign mx  = s_axis_tdata[47:24];
  always_comb begin
    if (mx <= 0 || cur <= 0) kind = grcr_pkg::KIND_ZERO;
    else if (cur >= mx)      kind = grcr_pkg::KIND_FULL;
    else                     kind = grcr_pkg::KIND_DIV;
  end

  logic               dv;
  logic [12:0]        ratio;
  grcr_divider u_div (
    .clk, .rst, .en,
    .in_valid (s_axis_tvalid),
    .cur      (cur),
    .mx       (mx),
    .kind     (kind),
    .out_valid(dv),
    .ratio    (ratio)
  );

  logic              rv;
  grcr_pkg::result_t res;
  grcr_ramp #(.STOP_SLOTS(STOP_SLOTS)) u_ramp (
    .clk, .rst, .en,
    .in_valid    (dv),
    .ratio       (ratio),
    .stop_count  (stop_count),
    .blend_enable(blend_enable),
    .stops       (stops),
    .out_valid   (rv),
    .result      (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= rv;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {3'b0, res.color[7:0], res.color[15:8], res.color[23:16],
                       res.color[31:24], res.ratio};
    end
  end

  // checks
  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[12:0] <= 13'd4096) else $error("ratio range");
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[47:45] == 3'b0) else $error("pad bits");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
endmodule
`default_nettype wire

>>> rtl/grcr_divider.sv
// ----------------------------------------------------------------------------
// grcr_divider: pipelined restoring divider for the fill ratio
// One quotient bit per stage, 12 stages; a stall freezes every stage.
// ----------------------------------------------------------------------------
`default_nettype none
module grcr_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [grcr_pkg::VAL_W-1:0]    cur,
  input  wire logic [grcr_pkg::VAL_W-1:0]    mx,
  input  wire logic [1:0]                    kind,
  output logic                               out_valid,
  output logic [grcr_pkg::RATIO_W-1:0]       ratio
);
  localparam int N = grcr_pkg::QUO_W;
  localparam int W = grcr_pkg::VAL_W;

  // kind selects divide, forced zero or forced full scale
  logic             vld [N+1];
  logic [W-1:0]     rem [N+1];
  logic [W-1:0]     dvs [N+1];
  logic [N-1:0]     quo [N+1];
  logic [1:0]       knd [N+1];

  assign vld[0] = in_valid;
  assign rem[0] = cur;
  assign dvs[0] = mx;
  assign quo[0] = '0;
  assign knd[0] = kind;

  // each stage: shift remainder, try subtract
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [W:0] sh;
    logic [W:0] diff;
    assign sh   = {rem[s], 1'b0};
    assign diff = sh - {1'b0, dvs[s]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= diff[W] ? sh[W-1:0] : diff[W-1:0];
        quo[s+1] <= {quo[s][N-2:0], ~diff[W]};
        dvs[s+1] <= dvs[s];
        knd[s+1] <= knd[s];
      end
    end
  end

  assign out_valid = vld[N];
  always_comb begin
    case (knd[N])
      grcr_pkg::KIND_ZERO: ratio = '0;
      grcr_pkg::KIND_FULL: ratio = grcr_pkg::RATIO_W'(grcr_pkg::FULL);
      default:             ratio = {1'b0, quo[N]};
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/grcr_ramp.sv
// ----------------------------------------------------------------------------
// grcr_ramp: color ramp lookup and blend
// Stage 1 picks the segment, stage 2 multiplies, stages 3..11 divide by width.
// ----------------------------------------------------------------------------
`default_nettype none
module grcr_ramp #(
  parameter int STOP_SLOTS = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [grcr_pkg::RATIO_W-1:0]  ratio,
  input  wire logic [2:0]                    stop_count,
  input  wire logic                          blend_enable,
  input  wire grcr_pkg::stop_t               stops [STOP_SLOTS],
  output logic                               out_valid,
  output grcr_pkg::result_t                  result
);
  localparam int RW = grcr_pkg::RATIO_W;
  localparam int PW = 8 + RW;       // product magnitude width
  localparam int QN = 9;            // quotient bits (quotient < 256, plus margin)

  // ---- stage 1 combinational: segment select ----
  logic [2:0]  n;
  logic [2:0]  last;
  logic        do_blend;
  logic [31:0] lo_col, hi_col;
  logic [RW-1:0] off, wid;
  always_comb begin
    n = (stop_count > 3'(STOP_SLOTS)) ? 3'(STOP_SLOTS) : stop_count;
    last = n - 3'd1;
    do_blend = 1'b0;
    lo_col = 32'hFFFF_FFFF;
    hi_col = 32'hFFFF_FFFF;
    off = '0;
    wid = '0;
    if (n != 3'd0) begin
      lo_col = stops[last].color;
      hi_col = stops[last].color;
      if (ratio <= stops[0].pos) begin
        lo_col = stops[0].color;
        hi_col = stops[0].color;
      end else if (ratio < stops[last].pos) begin
        // first matching segment wins: scan from the top down
        for (int i = STOP_SLOTS - 2; i >= 0; i--) begin
          if (3'(i + 1) < n && ratio >= stops[i].pos && ratio < stops[i+1].pos) begin
            lo_col = stops[i].color;
            hi_col = stops[i+1].color;
            off = ratio - stops[i].pos;
            wid = stops[i+1].pos - stops[i].pos;
            do_blend = blend_enable;
          end
        end
      end
    end
  end

  // ---- stage 1 registers ----
  logic          v1, b1;
  logic [RW-1:0] r1, off1, wid1;
  logic [31:0]   lo1, hi1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b1 <= do_blend; r1 <= ratio; off1 <= off; wid1 <= wid;
      lo1 <= lo_col; hi1 <= hi_col;
    end
  end

  // ---- stage 2: per-channel |b-a| * off ----
  logic          v2, b2;
  logic [RW-1:0] r2, wid2;
  logic [31:0]   lo2;
  logic [3:0]    neg2;
  logic [PW-1:0] prod2 [4];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  for (genvar c = 0; c < 4; c++) begin : g_mul
    logic [7:0] a, b, d;
    assign a = lo1[8*c +: 8];
    assign b = hi1[8*c +: 8];
    assign d = (b >= a) ? b - a : a - b;
    always_ff @(posedge clk) begin
      if (en) begin
        prod2[c] <= PW'(d) * PW'(off1);
        neg2[c]  <= b < a;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b2 <= b1; r2 <= r1; wid2 <= wid1; lo2 <= lo1;
    end
  end

  // ---- stages 3..: one quotient bit per stage, four lanes ----
  logic          vq  [QN+1];
  logic          bq  [QN+1];
  logic [RW-1:0] rq  [QN+1];
  logic [RW-1:0] wq  [QN+1];
  logic [31:0]   lq  [QN+1];
  logic [3:0]    nq  [QN+1];
  logic [PW-1:0] rem [QN+1][4];
  logic [QN-1:0] quo [QN+1][4];

  assign vq[0] = v2; assign bq[0] = b2; assign rq[0] = r2;
  assign wq[0] = wid2; assign lq[0] = lo2; assign nq[0] = neg2;
  for (genvar c = 0; c < 4; c++) begin : g_q0
    assign rem[0][c] = prod2[c];
    assign quo[0][c] = '0;
  end

  for (genvar s = 0; s < QN; s++) begin : g_dstage
    always_ff @(posedge clk) begin
      if (rst) vq[s+1] <= 1'b0;
      else if (en) vq[s+1] <= vq[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        bq[s+1] <= bq[s]; rq[s+1] <= rq[s]; wq[s+1] <= wq[s];
        lq[s+1] <= lq[s]; nq[s+1] <= nq[s];
      end
    end
    for (genvar c = 0; c < 4; c++) begin : g_lane
      // restoring step on bit position QN-1-s
      localparam int SH = QN - 1 - s;
      logic [PW+QN-1:0] dsh;
      logic             ge;
      assign dsh = (PW+QN)'(wq[s]) << SH;
      assign ge  = (PW+QN)'(rem[s][c]) >= dsh;
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1][c] <= ge ? PW'((PW+QN)'(rem[s][c]) - dsh) : rem[s][c];
          quo[s+1][c] <= {quo[s][c][QN-2:0], ge};
        end
      end
    end
  end

  // ---- output: apply sign and add low color ----
  always_comb begin
    result.ratio = rq[QN];
    result.color = lq[QN];
    if (bq[QN]) begin
      for (int c = 0; c < 4; c++) begin
        result.color[8*c +: 8] = nq[QN][c] ? lq[QN][8*c +: 8] - quo[QN][c][7:0]
                                           : lq[QN][8*c +: 8] + quo[QN][c][7:0];
      end
    end
  end
  assign out_valid = vq[QN];
endmodule
`default_nettype wire

>>> sim/tb_gauge_ratio_color_ramp_core.sv
// ----------------------------------------------------------------------------
// tb_gauge_ratio_color_ramp_core: self-checking bench of the gauge ramp core
// Drives value pairs through the stream input under several ramp settings and
// idle patterns, predicts fill ratio and tint per item, and compares every
// result in order against the predicted queue.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_gauge_ratio_color_ramp_core;

  localparam int SLOTS      = 6;
  localparam int DRAIN_WAIT = 40;
  localparam int CYCLE_CAP  = 400000;

  // result layout, lowest field last
  typedef struct packed {
    logic [7:0]                   alpha;
    logic [7:0]                   blue;
    logic [7:0]                   green;
    logic [7:0]                   red;
    logic [grcr_pkg::RATIO_W-1:0] ratio;
  } tint_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;    // current_value, max_value
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;    // fill_ratio, red, green, blue, alpha, pad
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [44:0] cfg_data;

  // predictor copy of the ramp registers
  logic [2:0]       ramp_count;
  logic             ramp_blend;
  grcr_pkg::stop_t  ramp_stop [SLOTS];

  logic [47:0] pair_queue [$];
  tint_t       tint_queue [$];
  logic        in_taken;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;
  int          errors;
  int          cycle_count;

  gauge_ratio_color_ramp_core #(.STOP_SLOTS(SLOTS)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // append one value pair to the pending queue
  task automatic enqueue_pair(logic [47:0] pair);
    pair_queue.insert(pair_queue.size(), pair);
  endtask

  // fill ratio and ramp tint for one value pair
  function automatic tint_t predict_tint(logic [47:0] pair);
    tint_t t;
    longint cur, mx, r, lo, hi, a, b;
    int n;
    bit found;
    logic [31:0] col;
    cur = longint'($signed(pair[23:0]));
    mx  = longint'($signed(pair[47:24]));
    if (mx <= 0 || cur <= 0) r = 0;
    else if (cur >= mx) r = grcr_pkg::FULL;
    else r = (cur * grcr_pkg::FULL) / mx;
    t.ratio = r[grcr_pkg::RATIO_W-1:0];
    n = (ramp_count > SLOTS) ? SLOTS : ramp_count;
    col = 32'hFFFF_FFFF;
    if (n != 0) begin
      found = 1'b0;
      if (r <= longint'(ramp_stop[0].pos)) begin
        col = ramp_stop[0].color; found = 1'b1;
      end else if (r >= longint'(ramp_stop[n-1].pos)) begin
        col = ramp_stop[n-1].color; found = 1'b1;
      end
      for (int i = 0; i + 1 < n && !found; i++) begin
        lo = ramp_stop[i].pos;
        hi = ramp_stop[i+1].pos;
        if (r >= lo && r < hi) begin
          found = 1'b1;
          col = ramp_stop[i].color;
          if (ramp_blend && hi > lo)
            for (int c = 0; c < 4; c++) begin
              a = ramp_stop[i].color[24-8*c +: 8];
              b = ramp_stop[i+1].color[24-8*c +: 8];
              col[24-8*c +: 8] = 8'(a + ((b - a) * (r - lo)) / (hi - lo));
            end
        end
      end
      if (!found) col = ramp_stop[n-1].color;
    end
    {t.red, t.green, t.blue, t.alpha} = col;
    return t;
  endfunction

  // driver: offers pending pairs, changes at falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (pair_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pair_queue.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // predictor hook on accepted input items
  always @(posedge clk) begin
    if (rst) in_taken <= 1'b0;
    else in_taken <= s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready)
      tint_queue.insert(tint_queue.size(), predict_tint(s_axis_tdata));
  end

  // receiver stall pattern, with a long hold-off when requested
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    tint_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[44:0];
      if (tint_queue.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        want = tint_queue.pop_front();
        if (got.ratio !== want.ratio)
          $display("%0t ratio exp %0d got %0d", $time, want.ratio, got.ratio);
        if (got.red !== want.red)
          $display("%0t red exp %0d got %0d", $time, want.red, got.red);
        if (got.green !== want.green)
          $display("%0t green exp %0d got %0d", $time, want.green, got.green);
        if (got.blue !== want.blue)
          $display("%0t blue exp %0d got %0d", $time, want.blue, got.blue);
        if (got.alpha !== want.alpha)
          $display("%0t alpha exp %0d got %0d", $time, want.alpha, got.alpha);
        if (got !== want) errors++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [44:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == grcr_pkg::REG_STOP_COUNT) ramp_count = val[2:0];
    else if (idx == grcr_pkg::REG_BLEND) ramp_blend = val[0];
    else if (idx >= grcr_pkg::REG_STOP_FIRST && idx - grcr_pkg::REG_STOP_FIRST < SLOTS)
      ramp_stop[idx - grcr_pkg::REG_STOP_FIRST] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pair_queue.size() > 0 || s_axis_tvalid || tint_queue.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // ramp setup: sorted, unsorted or random stops, with edge positions
  task automatic load_ramp(int kind, logic [2:0] count, logic blend);
    logic [12:0] p;
    p = 0;
    write_reg(grcr_pkg::REG_STOP_COUNT, 45'(count));
    write_reg(grcr_pkg::REG_BLEND, 45'(blend));
    for (int i = 0; i < SLOTS; i++) begin
      if (kind == 0) p = (i == 0) ? 13'($urandom_range(300)) : 13'(p + $urandom_range(1200));
      else if (kind == 1) p = 13'($urandom_range(4096));
      else p = 13'($urandom);
      write_reg(3'(grcr_pkg::REG_STOP_FIRST + i), {p, 32'($urandom)});
    end
  endtask

  function automatic logic [23:0] rand_value();
    case ($urandom_range(5))
      0: return 24'($urandom);
      1: return 24'h7FFFFF;
      2: return 24'h800000;
      default: return 24'($urandom_range(8000));
    endcase
  endfunction

  task automatic add_random(int count);
    logic [23:0] mx;
    for (int i = 0; i < count; i++) begin
      mx = rand_value();
      if ($urandom_range(9) < 7)
        enqueue_pair({mx, 24'($urandom_range(mx[23] ? 100 : mx + 20))});
      else
        enqueue_pair({mx, rand_value()});
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    hold_cycles = 0;
    errors = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    ramp_count = 0;
    ramp_blend = 1'b1;
    for (int i = 0; i < SLOTS; i++) ramp_stop[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset ramp gives white, then field extremes
    enqueue_pair({24'h000100, 24'h000080});
    enqueue_pair({24'h000000, 24'h000010});
    enqueue_pair({24'h800000, 24'h7FFFFF});
    wait_drained();
    write_reg(grcr_pkg::REG_STOP_COUNT, 45'd7);
    write_reg(grcr_pkg::REG_BLEND, 45'd1);
    write_reg(3'(grcr_pkg::REG_STOP_FIRST + 0), {13'd0,    32'h0000_00FF});
    write_reg(3'(grcr_pkg::REG_STOP_FIRST + 1), {13'd1000, 32'hFF80_40FF});
    write_reg(3'(grcr_pkg::REG_STOP_FIRST + 2), {13'd1000, 32'h1020_3040});
    write_reg(3'(grcr_pkg::REG_STOP_FIRST + 3), {13'd2048, 32'hFFFF_FFFF});
    write_reg(3'(grcr_pkg::REG_STOP_FIRST + 4), {13'd1500, 32'h0102_0304});
    write_reg(3'(grcr_pkg::REG_STOP_FIRST + 5), {13'h1FFF, 32'hA5A5_5A5A});
    enqueue_pair({24'h7FFFFF, 24'h7FFFFF});
    enqueue_pair({24'h7FFFFF, 24'h7FFFFE});
    enqueue_pair({24'h7FFFFF, 24'h000001});
    enqueue_pair({24'h000400, 24'h000100});
    enqueue_pair({24'h000400, 24'h0000FA});
    enqueue_pair({24'h000400, 24'h000200});
    enqueue_pair({24'h000400, 24'h000300});
    enqueue_pair({24'h000400, 24'h000180});
    enqueue_pair({24'h000400, 24'h0003FF});
    enqueue_pair({24'h000400, 24'h000500});
    enqueue_pair({24'hFFFFFF, 24'h000001});
    enqueue_pair({24'h000000, 24'h000000});
    wait_drained();
    write_reg(grcr_pkg::REG_BLEND, 45'd0);
    enqueue_pair({24'h000400, 24'h0000FA});
    enqueue_pair({24'h000400, 24'h000300});
    wait_drained();

    // random phases under the idle patterns
    for (int ph = 0; ph < 12; ph++) begin
      load_ramp(ph % 3, 3'($urandom_range(7)), 1'($urandom_range(1)));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      if (ph == 4) begin
        send_idle_pct = 0;
        hold_cycles = 300;
      end
      add_random(ph == 6 ? 60 : 125);
      if (ph == 6) begin
        // sender pause until everything drained
        while (pair_queue.size() > 0 || s_axis_tvalid || tint_queue.size() > 0)
          @(posedge clk);
        add_random(65);
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
